FILE: rtl/core/bam_pkg.sv
// Package for the allocation bitmap block: request/response payload types,
// request kind codes and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bam_pkg;

    // Default sizes; the word width is expected to be a power of two.
    localparam int MAP_BITS_MAX_DEF = 4096;
    localparam int WORD_BITS_DEF    = 32;

    // Fixed field widths of the interface
    localparam int CFG_W = 13;
    localparam int IDX_W = 12;

    // Reset value of the map size register
    localparam logic [CFG_W-1:0] MAP_BITS_RST = 13'd4096;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_TEST  = 2'd0,
        KIND_SET   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_FIND  = 2'd3
    } t_kind;

    // Request transaction payload
    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   bit_index;
    } t_req;

    // Response transaction payload
    typedef struct packed {
        logic               old_bit;
        logic [CFG_W-1:0]   found_index;
    } t_rsp;

endpackage

`default_nettype wire

FILE: rtl/core/bitmap_alloc_map_top.sv
// Allocation bitmap with test/set/clear/find-next-zero requests.
// Depends on bam_pkg, bam_ram and bam_zero_unit.
//
// After reset the block clears every one of the DEPTH words of the map
// (MAP_BITS_MAX / WORD_BITS rounded up, 128 by default) with busy high;
// configuration writes are taken during it. A test, set or clear reads
// the word, then writes it back and posts the result. A find scans one
// bitmap word per cycle through the lowest-zero unit fed by the RAM's
// registered read port; a find that starts at or past the map size, and
// a test/set/clear past the storage, answer straight from idle without
// a RAM access. Each result is shown for exactly one cycle with
// o_res_strobe; the receiver cannot stall it, and a new request may be
// accepted in that same cycle.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_alloc_map_top
    import bam_pkg::*;
#(
    parameter int MAP_BITS_MAX = MAP_BITS_MAX_DEF,
    parameter int WORD_BITS    = WORD_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_req             i_req,
    output logic                  o_res_strobe,
    output t_rsp                  o_rsp,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CFG_W-1:0] i_cfg_wr_data
);

    localparam int DEPTH = (MAP_BITS_MAX + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WB    = $clog2(WORD_BITS);
    localparam int SZW   = ($clog2(MAP_BITS_MAX + 1) > CFG_W) ?
                           $clog2(MAP_BITS_MAX + 1) : CFG_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW_RD,
        S_RMW_WR,
        S_SCAN
    } t_state;

    t_state               r_state;
    logic [AW-1:0]        r_clr_addr;
    logic [CFG_W-1:0]     r_map_bits;
    t_kind                r_kind;
    logic [AW-1:0]        r_word;
    logic [WB-1:0]        r_bit;
    logic [AW-1:0]        r_scan_w;
    logic [AW-1:0]        r_eval_w;
    logic [AW-1:0]        r_first_w;
    logic [AW-1:0]        r_last_w;
    logic                 r_eval_vld;
    logic                 r_res_vld;
    logic                 r_res_old;
    logic [SZW-1:0]       r_res_found;

    logic [SZW-1:0]       size_w;
    logic [SZW-1:0]       size_m1;
    logic [SZW-1:0]       idx_ext;
    logic [AW-1:0]        in_word;
    logic [AW-1:0]        last_w;
    logic [SZW-1:0]       eval_n;
    logic [SZW-1:0]       eval_res;
    logic                 clr_done;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] mod_word;

    logic                 zu_hit;
    logic [WB-1:0]        zu_pos;

    // Map size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_bits <= MAP_BITS_RST;
        end else if (i_cfg_wr_en) begin
            r_map_bits <= i_cfg_wr_data;
        end
    end

    // Size in use, clamped to the storage
    assign size_w  = (SZW'(r_map_bits) > SZW'(MAP_BITS_MAX)) ?
                     SZW'(MAP_BITS_MAX) : SZW'(r_map_bits);
    assign size_m1 = size_w - SZW'(1);
    assign idx_ext = SZW'(i_req.bit_index);
    assign in_word = AW'(idx_ext >> WB);
    assign last_w  = AW'(size_m1 >> WB);
    assign clr_done = (r_clr_addr == AW'(DEPTH - 1));

    // Scan candidate index, clamped to the size
    assign eval_n   = (SZW'(r_eval_w) << WB) | SZW'(zu_pos);
    assign eval_res = (eval_n < size_w) ? eval_n : size_w;

    // Read-modify-write data
    always_comb begin
        mod_word = ram_rdata;
        case (r_kind)
            KIND_SET:   mod_word[r_bit] = 1'b1;
            KIND_CLEAR: mod_word[r_bit] = 1'b0;
            default:    mod_word = ram_rdata;
        endcase
    end

    // RAM port steering
    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_RMW_WR);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_word;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : mod_word;
    assign ram_raddr = (r_state == S_SCAN) ? r_scan_w : r_word;

    bam_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bam_zero_unit #(
        .WORD_BITS (WORD_BITS),
        .WB        (WB)
    ) u_zero (
        .i_word  (ram_rdata),
        .i_first (r_eval_w == r_first_w),
        .i_off   (r_first_w == r_eval_w ? r_bit : '0),
        .o_hit   (zu_hit),
        .o_pos   (zu_pos)
    );

    // Sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_eval_vld <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            r_res_vld <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (clr_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_kind <= i_req.kind;
                        r_word <= in_word;
                        r_bit  <= i_req.bit_index[WB-1:0];
                        if (i_req.kind == KIND_FIND) begin
                            if (idx_ext >= size_w) begin
                                r_res_vld   <= 1'b1;
                                r_res_old   <= 1'b0;
                                r_res_found <= size_w;
                            end else begin
                                r_scan_w   <= in_word;
                                r_first_w  <= in_word;
                                r_last_w   <= last_w;
                                r_eval_vld <= 1'b0;
                                r_state    <= S_SCAN;
                            end
                        end else if (idx_ext >= SZW'(MAP_BITS_MAX)) begin
                            // bit beyond storage: no change, old bit reads 0
                            r_res_vld   <= 1'b1;
                            r_res_old   <= 1'b0;
                            r_res_found <= '0;
                        end else begin
                            r_state <= S_RMW_RD;
                        end
                    end
                end
                S_RMW_RD: begin
                    r_state <= S_RMW_WR;
                end
                S_RMW_WR: begin
                    r_res_vld   <= 1'b1;
                    r_res_old   <= ram_rdata[r_bit];
                    r_res_found <= '0;
                    r_state     <= S_IDLE;
                end
                S_SCAN: begin
                    // issue one word read per cycle, evaluate the previous one
                    r_eval_w   <= r_scan_w;
                    r_eval_vld <= 1'b1;
                    if (r_scan_w != r_last_w) begin
                        r_scan_w <= r_scan_w + AW'(1);
                    end
                    if (r_eval_vld) begin
                        if (zu_hit) begin
                            r_res_vld   <= 1'b1;
                            r_res_old   <= 1'b0;
                            r_res_found <= eval_res;
                            r_state     <= S_IDLE;
                        end else if (r_eval_w == r_last_w) begin
                            r_res_vld   <= 1'b1;
                            r_res_old   <= 1'b0;
                            r_res_found <= size_w;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Outputs
    assign busy              = (r_state != S_IDLE);
    assign o_res_strobe      = r_res_vld;
    assign o_rsp.old_bit     = r_res_old;
    assign o_rsp.found_index = CFG_W'(r_res_found);

    // An accepted transaction either posts a result at once or keeps busy up
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_res_strobe))
        else $error("accepted transaction neither busy nor answered");

    // Every result follows an accept or a busy cycle
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> ($past(busy) || $past(start)))
        else $error("result without a transaction");

    // A find result never lies past the size in use
    a_found_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> (r_res_found <= size_w))
        else $error("found index past map size");

    // The scan never evaluates a word past the last word of the map
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_eval_vld) |-> (r_eval_w <= r_last_w))
        else $error("scan ran past last word");

endmodule

`default_nettype wire

FILE: rtl/core/bam_ram.sv
// Bitmap word storage: one write port, one read port with registered data.
// Depends on nothing; sizes come in as parameters.
`timescale 1ns / 1ps
`default_nettype none

module bam_ram #(
    parameter int DEPTH     = 128,
    parameter int WORD_BITS = 32,
    parameter int AW        = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WORD_BITS-1:0] i_wdata,
    input  wire logic [AW-1:0]        i_raddr,
    output logic      [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/bam_zero_unit.sv
// Lowest-zero search over one bitmap word, with the bits below the start
// offset masked on the first word of a scan. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bam_zero_unit #(
    parameter int WORD_BITS = 32,
    parameter int WB        = 5
) (
    input  wire logic [WORD_BITS-1:0] i_word,
    input  wire logic                 i_first,
    input  wire logic [WB-1:0]        i_off,
    output logic                      o_hit,
    output logic      [WB-1:0]        o_pos
);

    logic [WORD_BITS-1:0] low_mask;
    logic [WORD_BITS-1:0] zeros;
    logic [WORD_BITS-1:0] lowest;

    // Free bits, only at or above the start offset on the first word
    assign low_mask = (WORD_BITS'(1) << i_off) - WORD_BITS'(1);
    assign zeros    = ~i_word & ~(i_first ? low_mask : '0);

    // Isolate the lowest free bit, then encode its position
    assign lowest = zeros & (~zeros + WORD_BITS'(1));
    assign o_hit  = |zeros;

    always_comb begin
        o_pos = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (lowest[i]) begin
                o_pos = o_pos | WB'(i);
            end
        end
    end

endmodule

`default_nettype wire
